FILE: rtl/dwf_pkg.sv
// Shared widths, fixed-point constants and tables for the dose-weighting filter.
package dwf_pkg;

    // Configuration and field widths
    localparam int DIM_W     = 13;
    localparam int IDX_W     = 12;
    localparam int DOSE_W    = 24;
    localparam int PIX_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 4096;
    localparam int COEF_WIDTH_DEF = 32;

    // Log unit: input width, exponent width, mantissa width
    localparam int LG_IN_W = 2 * (2 * DIM_W) + 1;
    localparam int LG_N_W  = 6;
    localparam int LG_FR_W = 16;
    localparam int LG_W    = LG_N_W + LG_FR_W;
    localparam int Y_W     = 31;
    localparam int LG_LAT  = 2 + LG_FR_W;

    // Fractional power unit: Q2.30 accumulator over 16 root factors
    localparam int FR_W    = 16;
    localparam int M_W     = 32;
    localparam int ROOT_W  = 31;
    localparam int FRAC_Q  = 30;
    localparam int EXP_LAT = FR_W;
    localparam logic [M_W-1:0] M_ONE  = M_W'(64'd1 << FRAC_Q);
    localparam logic [M_W-1:0] M_HALF = M_W'(64'd1 << (FRAC_Q - 1));

    // Dose arithmetic
    localparam int P16_W  = 48;
    localparam int CRIT_W = 48;
    localparam int OPT_W  = 50;
    localparam int QUO_W  = 21;
    localparam int DIV_LAT = QUO_W + 1;
    localparam int W_W    = 17;

    localparam logic [15:0] K_EXP          = 16'd54555;
    localparam logic [13:0] A_Q16          = 14'd16056;
    localparam logic [17:0] C_Q16          = 18'd184425;
    localparam logic [15:0] V200_Q16       = 16'd52429;
    localparam logic [17:0] OPT_Q16        = 18'd164681;
    localparam logic [15:0] HALF_LOG2E_Q16 = 16'd47274;

    // 2^(2^-k) in Q2.30, k = 1..16
    localparam logic [ROOT_W-1:0] POW2_ROOT [FR_W] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572137, 31'd1076653033,
        31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923543,
        31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_PIXEL_SIZE   = 2'd2,
        CFG_VOLTAGE_SEL  = 2'd3
    } t_cfg_idx;

endpackage

FILE: rtl/dwf_delay.sv
// Enabled shift line that carries side data alongside the arithmetic stages.
module dwf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

FILE: rtl/dwf_log2.sv
// Pipelined base-2 logarithm, Q.16, by leading-one normalise and repeated squaring.
module dwf_log2
    import dwf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [LG_IN_W-1:0] i_x,
    output logic [LG_W-1:0]    o_lg
);

    logic [LG_IN_W-1:0] r_x;
    logic [LG_N_W-1:0]  r_n0;
    logic [LG_N_W-1:0]  n_n;
    logic [LG_IN_W-1:0] norm;

    logic [Y_W-1:0]     r_y [LG_FR_W+1];
    logic [LG_FR_W-1:0] r_r [LG_FR_W+1];
    logic [LG_N_W-1:0]  r_n [LG_FR_W+1];

    // leading one position
    always_comb begin
        n_n = '0;
        for (int i = 0; i < LG_IN_W; i++) begin
            if (i_x[i]) n_n = LG_N_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_n0 <= n_n;
        end
    end

    // normalise: top Y_W bits hold the mantissa in Q1.30
    assign norm = r_x << (LG_N_W'(LG_IN_W - 1) - r_n0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0] <= norm[LG_IN_W-1 -: Y_W];
            r_r[0] <= '0;
            r_n[0] <= r_n0;
        end
    end

    // one fraction bit per stage
    for (genvar g = 1; g <= LG_FR_W; g++) begin : g_sq
        logic [2*Y_W-1:0] sq;
        logic [Y_W:0]     t;
        always_comb begin
            sq = (2*Y_W)'(r_y[g-1]) * (2*Y_W)'(r_y[g-1]);
            t  = (Y_W+1)'(sq >> FRAC_Q);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[g] <= t[Y_W] ? t[Y_W:1] : t[Y_W-1:0];
                r_r[g] <= {r_r[g-1][LG_FR_W-2:0], t[Y_W]};
                r_n[g] <= r_n[g-1];
            end
        end
    end

    assign o_lg = {r_n[LG_FR_W], r_r[LG_FR_W]};

endmodule

FILE: rtl/dwf_exp2frac.sv
// Pipelined 2^(fraction) in Q2.30 from a product of root factors, one bit per stage.
module dwf_exp2frac
    import dwf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [FR_W-1:0] i_fr,
    output logic [M_W-1:0]  o_m
);

    logic [M_W-1:0]  r_acc [EXP_LAT];
    logic [FR_W-1:0] r_fr  [EXP_LAT];

    for (genvar g = 0; g < EXP_LAT; g++) begin : g_stage
        logic [M_W-1:0]        acc_in;
        logic [FR_W-1:0]       fr_in;
        logic [M_W+ROOT_W-1:0] prod;
        logic [M_W-1:0]        n_acc;

        if (g == 0) begin : g_first
            assign acc_in = M_ONE;
            assign fr_in  = i_fr;
        end else begin : g_next
            assign acc_in = r_acc[g-1];
            assign fr_in  = r_fr[g-1];
        end

        // multiply in the root for this bit, rounded half up
        always_comb begin
            prod  = (M_W+ROOT_W)'(acc_in) * (M_W+ROOT_W)'(POW2_ROOT[g])
                  + (M_W+ROOT_W)'(M_HALF);
            n_acc = fr_in[FR_W-1-g] ? M_W'(prod >> FRAC_Q) : acc_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[g] <= n_acc;
                r_fr[g]  <= fr_in;
            end
        end
    end

    assign o_m = r_acc[EXP_LAT-1];

endmodule

FILE: rtl/dwf_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
module dwf_div
    import dwf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [P16_W-1:0]  i_num,
    input  logic [CRIT_W-1:0] i_den,
    output logic [QUO_W-1:0]  o_quo,
    output logic              o_ovf
);

    localparam int DW = CRIT_W + QUO_W;

    logic [P16_W-1:0]  r_rem [QUO_W+1];
    logic [CRIT_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0]  r_q   [QUO_W+1];
    logic              r_ovf [QUO_W+1];

    // quotient does not fit: weight is zero anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= DW'(i_num) >= (DW'(i_den) << QUO_W);
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        logic [DW-1:0] trial;
        logic          ge;
        always_comb begin
            trial = DW'(r_den[s-1]) << (QUO_W - s);
            ge    = DW'(r_rem[s-1]) >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? P16_W'(DW'(r_rem[s-1]) - trial) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= {r_q[s-1][QUO_W-2:0], ge};
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_q[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

FILE: rtl/dose_weighting_fourier_filter_core.sv
// Exposure dose weighting of half-complex spectrum coefficients.
// Pipeline: the 18-stage log, the two 16-stage power chains and the 22-stage divider,
// plus the glue stages between them.
// Throughput: one beat per cycle; the pipeline advances unless the output stage
// holds a beat that is stalled.
// Reset (synchronous, active low) clears the valid bits and loads the register defaults.
module dose_weighting_fourier_filter_core
    import dwf_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DAT_W-1:0]         i_cfg_data,
    // input beats
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [IDX_W-1:0]             i_row_index,
    input  logic [IDX_W-1:0]             i_col_index,
    input  logic signed [COEF_WIDTH-1:0] i_coef_re,
    input  logic signed [COEF_WIDTH-1:0] i_coef_im,
    input  logic [DOSE_W-1:0]            i_dose_begin,
    input  logic [DOSE_W-1:0]            i_dose_end,
    // result beats
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COEF_WIDTH-1:0] o_out_re,
    output logic signed [COEF_WIDTH-1:0] o_out_im,
    output logic                         o_dropped
);

    // stage numbers, counted in registers after the input
    localparam int ST_LG      = 2 + LG_LAT;
    localparam int ST_EXP_IN  = ST_LG + 3;
    localparam int ST_EXP_OUT = ST_EXP_IN + EXP_LAT;
    localparam int ST_CRIT    = ST_EXP_OUT + 4;
    localparam int ST_DIV_OUT = ST_CRIT + DIV_LAT;
    localparam int ST_W_IN    = ST_DIV_OUT + 1;
    localparam int ST_W_OUT   = ST_W_IN + EXP_LAT;
    localparam int ST_OUT     = ST_W_OUT + 2;

    localparam int PRD1_W = 2 * DIM_W;
    localparam int L_W    = LG_W + 3;
    localparam int IP_W   = 10;
    localparam int CW2    = 2 * COEF_WIDTH;
    localparam int PW     = COEF_WIDTH + W_W + 1;

    // configuration registers
    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;
    logic [PIX_W-1:0] r_pixel_size;
    logic             r_voltage_sel;

    logic             en;
    logic [ST_OUT-1:0] r_vld;

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] d);
        if (d < DIM_W'(2)) return DIM_W'(2);
        if (int'(d) > MAX_DIM) return DIM_W'(MAX_DIM);
        return d;
    endfunction

    // magnitude of the signed digital frequency numerator
    function automatic logic [DIM_W-1:0] f_mag(input logic [IDX_W-1:0] idx,
                                               input logic [DIM_W-1:0] size);
        logic [DIM_W-1:0] ix;
        ix = DIM_W'(idx);
        if (ix <= (size >> 1)) return ix;
        if (ix >= size) return ix - size;
        return size - ix;
    endfunction

    // v*w/2^16 rounded half away from zero, saturated
    function automatic logic [COEF_WIDTH-1:0] f_scale(input logic [COEF_WIDTH-1:0] v,
                                                      input logic [W_W-1:0] w);
        logic          neg;
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        logic [PW-1:0] sgn;
        neg = v[COEF_WIDTH-1];
        sgn = PW'(1) << (COEF_WIDTH - 1);
        mag = neg ? (PW'(1) << COEF_WIDTH) - PW'(v) : PW'(v);
        q   = (mag * PW'(w) + PW'(32768)) >> 16;
        if (neg) begin
            if (q > sgn) q = sgn;
            return COEF_WIDTH'(-q);
        end
        if (q > sgn - PW'(1)) q = sgn - PW'(1);
        return COEF_WIDTH'(q);
    endfunction

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(4096);
            r_image_height <= DIM_W'(4096);
            r_pixel_size   <= PIX_W'(4096);
            r_voltage_sel  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                CFG_PIXEL_SIZE:   r_pixel_size   <= i_cfg_data[PIX_W-1:0];
                CFG_VOLTAGE_SEL:  r_voltage_sel  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // global advance: only a stalled result beat holds the pipe
    assign en      = !(r_vld[ST_OUT-1] && i_stall);
    assign o_stall = r_vld[ST_OUT-1] && i_stall;
    assign o_valid = r_vld[ST_OUT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-2:0], i_valid};
        end
    end

    // stage 1: frequency magnitudes times the opposite size
    logic [DIM_W-1:0]  cw, ch;
    logic [PIX_W-1:0]  pix;
    logic [PRD1_W-1:0] r1_axh, r1_ayw, r1_wh;
    logic [2*PIX_W-1:0] r1_pp;
    logic              r1_dckeep;
    logic [CW2-1:0]    r1_coef;
    logic [2*DOSE_W-1:0] r1_dose;

    always_comb begin
        cw  = f_clamp(r_image_width);
        ch  = f_clamp(r_image_height);
        pix = (r_pixel_size == '0) ? PIX_W'(1) : r_pixel_size;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_axh    <= PRD1_W'(f_mag(i_col_index, cw)) * PRD1_W'(ch);
            r1_ayw    <= PRD1_W'(f_mag(i_row_index, ch)) * PRD1_W'(cw);
            r1_wh     <= PRD1_W'(cw) * PRD1_W'(ch);
            r1_pp     <= (2*PIX_W)'(pix) * (2*PIX_W)'(pix);
            r1_dckeep <= i_dose_end > i_dose_begin;
            r1_coef   <= {i_coef_re, i_coef_im};
            r1_dose   <= {i_dose_begin, i_dose_end};
        end
    end

    // stage 2: squared radius numerator and normalising terms
    logic [LG_IN_W-1:0] r2_num, r2_whsq, r2_pp;
    logic               r2_dckeep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_num    <= LG_IN_W'((2*PRD1_W)'(r1_axh) * (2*PRD1_W)'(r1_axh))
                       + LG_IN_W'((2*PRD1_W)'(r1_ayw) * (2*PRD1_W)'(r1_ayw));
            r2_whsq   <= LG_IN_W'((2*PRD1_W)'(r1_wh) * (2*PRD1_W)'(r1_wh));
            r2_pp     <= LG_IN_W'(r1_pp);
            r2_dckeep <= r1_dckeep;
        end
    end

    // logarithms
    logic [LG_W-1:0] lg_num, lg_wh, lg_pp;

    dwf_log2 u_lg_num (.i_clk(i_clk), .i_en(en), .i_x(r2_num),  .o_lg(lg_num));
    dwf_log2 u_lg_wh  (.i_clk(i_clk), .i_en(en), .i_x(r2_whsq), .o_lg(lg_wh));
    dwf_log2 u_lg_pp  (.i_clk(i_clk), .i_en(en), .i_x(r2_pp),   .o_lg(lg_pp));

    // side data
    logic [CW2-1:0]      coef_d;
    logic [2*DOSE_W-1:0] dose_d;
    logic [1:0]          dc_d;

    dwf_delay #(.WIDTH(CW2), .DEPTH(ST_OUT - 2)) u_dl_coef (
        .i_clk(i_clk), .i_en(en), .i_d(r1_coef), .o_q(coef_d));
    dwf_delay #(.WIDTH(2*DOSE_W), .DEPTH(ST_CRIT - 1)) u_dl_dose (
        .i_clk(i_clk), .i_en(en), .i_d(r1_dose), .o_q(dose_d));
    dwf_delay #(.WIDTH(2), .DEPTH(ST_OUT - 4)) u_dl_dc (
        .i_clk(i_clk), .i_en(en), .i_d({r2_num == '0, r2_dckeep}), .o_q(dc_d));

    // log2(f^2) in Q.16
    logic signed [L_W-1:0] r_l;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l <= $signed(L_W'(lg_num)) - $signed(L_W'(lg_wh))
                 + $signed(L_W'(24 << 16)) - $signed(L_W'(lg_pp));
        end
    end

    // exponent e = -0.83245 * log2(f^2), rounded half away from zero
    logic [L_W-1:0]        lmag;
    logic [L_W+15:0]       lprod;
    logic [L_W-1:0]        lq;
    logic signed [L_W-1:0] r_e;

    always_comb begin
        lmag  = r_l[L_W-1] ? L_W'(-r_l) : L_W'(r_l);
        lprod = (L_W+16)'(lmag) * (L_W+16)'(K_EXP) + (L_W+16)'(32768);
        lq    = L_W'(lprod >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e <= r_l[L_W-1] ? $signed(lq) : -$signed(lq);
        end
    end

    // split exponent into integer and fraction
    logic [L_W-1:0]         eb;
    logic                   r_zf;
    logic signed [IP_W-1:0] r_ip;
    logic [FR_W-1:0]        r_fr;

    assign eb = L_W'(r_e + $signed(L_W'(64 << 16)));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zf <= r_e < -$signed(L_W'(64 << 16));
            r_ip <= $signed(IP_W'(eb >> 16)) - $signed(IP_W'(64));
            r_fr <= eb[FR_W-1:0];
        end
    end

    logic [M_W-1:0] exp_m;
    logic [IP_W:0]  ip_d;

    dwf_exp2frac u_exp_f (.i_clk(i_clk), .i_en(en), .i_fr(r_fr), .o_m(exp_m));
    dwf_delay #(.WIDTH(IP_W + 1), .DEPTH(EXP_LAT)) u_dl_ip (
        .i_clk(i_clk), .i_en(en), .i_d({r_zf, r_ip}), .o_q(ip_d));

    // 2^e in Q.16
    logic signed [IP_W-1:0] ipx, sh;
    logic [IP_W-1:0]        nsh;
    logic [39:0]            rnd;
    logic [P16_W-1:0]       n_p16, r_p16;

    always_comb begin
        ipx   = $signed(ip_d[IP_W-1:0]);
        sh    = ipx - $signed(IP_W'(14));
        nsh   = IP_W'(-sh);
        rnd   = '0;
        n_p16 = '0;
        if (ip_d[IP_W]) begin
            n_p16 = '0;
        end else if (ipx >= $signed(IP_W'(31))) begin
            n_p16 = P16_W'(1) << (P16_W - 1);
        end else if (sh >= 0) begin
            n_p16 = P16_W'(exp_m) << sh[4:0];
        end else if (nsh >= IP_W'(40)) begin
            n_p16 = '0;
        end else begin
            rnd   = (40'(exp_m) + (40'd1 << (nsh - IP_W'(1)))) >> nsh;
            n_p16 = P16_W'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_p16 <= n_p16;
    end

    // critical dose, voltage scale, optimal dose
    logic [CRIT_W-1:0] r_crit, r_crit_v, r43_crit;
    logic [OPT_W-1:0]  r43_opt;
    logic [65:0]       opt_prod;

    assign opt_prod = 66'(r_crit_v) * 66'(OPT_Q16) + 66'(32768);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crit   <= CRIT_W'((64'(r_p16) * 64'(A_Q16) + 64'(32768)) >> 16) + CRIT_W'(C_Q16);
            r_crit_v <= r_voltage_sel ? r_crit
                      : CRIT_W'((64'(r_crit) * 64'(V200_Q16) + 64'(32768)) >> 16);
            r43_crit <= r_crit_v;
            r43_opt  <= OPT_W'(opt_prod >> 16);
        end
    end

    // keep test: end dose strictly nearer the optimum than start dose
    logic [OPT_W-1:0] b16, e16, de, db;
    logic             keep43, keep_d;

    always_comb begin
        b16    = OPT_W'(dose_d[2*DOSE_W-1:DOSE_W]) << 8;
        e16    = OPT_W'(dose_d[DOSE_W-1:0]) << 8;
        de     = (e16 > r43_opt) ? e16 - r43_opt : r43_opt - e16;
        db     = (b16 > r43_opt) ? b16 - r43_opt : r43_opt - b16;
        keep43 = de < db;
    end

    logic [QUO_W-1:0] quo;
    logic             ovf;

    dwf_div u_div (
        .i_clk(i_clk), .i_en(en),
        .i_num(P16_W'(dose_d[DOSE_W-1:0]) << 24),
        .i_den(r43_crit),
        .o_quo(quo), .o_ovf(ovf));
    dwf_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_dl_keep (
        .i_clk(i_clk), .i_en(en), .i_d(keep43), .o_q(keep_d));

    // x = r * 0.5*log2(e); split for 2^-x
    logic [QUO_W+15:0] xprod;
    logic [QUO_W-1:0]  x16;
    logic              r_wz, r_keep;
    logic [4:0]        r_k;
    logic [FR_W-1:0]   r_nfr;

    always_comb begin
        xprod = (QUO_W+16)'(quo) * (QUO_W+16)'(HALF_LOG2E_Q16) + (QUO_W+16)'(32768);
        x16   = QUO_W'(xprod >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz   <= ovf || (x16 >= QUO_W'(17 << 16));
            r_k    <= x16[20:16] + 5'(x16[15:0] != '0);
            r_nfr  <= FR_W'(-x16[15:0]);
            r_keep <= keep_d;
        end
    end

    logic [M_W-1:0] w_m;
    logic [6:0]     wk_d;

    dwf_exp2frac u_exp_w (.i_clk(i_clk), .i_en(en), .i_fr(r_nfr), .o_m(w_m));
    dwf_delay #(.WIDTH(7), .DEPTH(EXP_LAT)) u_dl_wk (
        .i_clk(i_clk), .i_en(en), .i_d({r_wz, r_keep, r_k}), .o_q(wk_d));

    // weight in Q.16; DC overrides
    logic [M_W+1:0] wsum;
    logic [5:0]     wsh;
    logic [W_W-1:0] wgt;
    logic [W_W-1:0] r_w;
    logic           r_fkeep;

    always_comb begin
        wsh  = 6'd14 + 6'(wk_d[4:0]);
        wsum = (M_W+2)'(w_m) + ((M_W+2)'(1) << (wsh - 6'd1));
        wgt  = wk_d[6] ? '0 : W_W'(wsum >> wsh);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w     <= dc_d[1] ? W_W'(65536) : wgt;
            r_fkeep <= dc_d[1] ? dc_d[0] : wk_d[5];
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_re  <= r_fkeep ? f_scale(coef_d[CW2-1:COEF_WIDTH], r_w) : '0;
            o_out_im  <= r_fkeep ? f_scale(coef_d[COEF_WIDTH-1:0], r_w) : '0;
            o_dropped <= !r_fkeep;
        end
    end

endmodule
